FILE: sv/iqo_pkg.sv
package iqo_pkg;

	localparam int ELEMENT_BITS = 3;
	localparam int ORDER = 1 << ELEMENT_BITS;
	localparam int TABLE_W = ELEMENT_BITS * ORDER;
	localparam int MODE_W = 2;
	localparam int OP_W = 2;
	localparam int CFG_IDX_W = 2;

	typedef logic [ELEMENT_BITS-1:0] elem_t;
	typedef logic [TABLE_W-1:0] table_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [OP_W-1:0] op_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam op_t OP_PRODUCT = 2'd0;
	localparam op_t OP_LDIV = 2'd1;
	localparam op_t OP_RDIV = 2'd2;

	localparam mode_t MODE_XOR = 2'd0;
	localparam mode_t MODE_ADD = 2'd1;
	localparam mode_t MODE_SUB = 2'd2;

	localparam cfg_idx_t REG_PERM_OUT = 2'd0;
	localparam cfg_idx_t REG_PERM_LEFT = 2'd1;
	localparam cfg_idx_t REG_PERM_RIGHT = 2'd2;
	localparam cfg_idx_t REG_GROUP_MODE = 2'd3;

	// Stage 1 result: two looked-up (or inverted) operands
	typedef struct packed {
		op_t   op;
		elem_t p;
		elem_t q;
	} s1_t;

	// Stage 2 result: the group element to resolve
	typedef struct packed {
		op_t   op;
		elem_t g;
	} s2_t;

	function automatic table_t identity_table();
		table_t t;
		t = '0;
		for (int i = 0; i < ORDER; i++) begin
			t[i*ELEMENT_BITS +: ELEMENT_BITS] = elem_t'(i);
		end
		return t;
	endfunction

	localparam table_t IDENTITY = identity_table();

	function automatic elem_t tbl_lookup(table_t t, elem_t idx);
		return t[idx*ELEMENT_BITS +: ELEMENT_BITS];
	endfunction

	// Lowest matching index wins; zero when nothing matches
	function automatic elem_t tbl_inverse(table_t t, elem_t v);
		elem_t res;
		res = '0;
		for (int i = ORDER - 1; i >= 0; i--) begin
			if (t[i*ELEMENT_BITS +: ELEMENT_BITS] == v) begin
				res = elem_t'(i);
			end
		end
		return res;
	endfunction

endpackage

FILE: sv/iqo_ifs.sv
interface iqo_in_if;
	logic               valid;
	logic               ready;
	iqo_pkg::op_t       opcode;
	iqo_pkg::elem_t     first_operand;
	iqo_pkg::elem_t     second_operand;

	modport source (output valid, output opcode, output first_operand,
		output second_operand, input ready);
	modport sink (input valid, input opcode, input first_operand,
		input second_operand, output ready);
endinterface

interface iqo_out_if;
	logic               valid;
	logic               ready;
	iqo_pkg::elem_t     answer;

	modport source (output valid, output answer, input ready);
	modport sink (input valid, input answer, output ready);
endinterface

FILE: sv/iqo_front.sv
module iqo_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  iqo_pkg::op_t      op,
	input  iqo_pkg::elem_t    a,
	input  iqo_pkg::elem_t    b,
	input  iqo_pkg::table_t   perm_out,
	input  iqo_pkg::table_t   perm_left,
	input  iqo_pkg::table_t   perm_right,
	output logic              valid_s1,
	output iqo_pkg::s1_t      data_s1
);

	iqo_pkg::s1_t nxt;

	// Right division inverts the outer table on a, left division on b
	always_comb begin
		nxt.op = op;
		nxt.p = (op == iqo_pkg::OP_RDIV) ? iqo_pkg::tbl_inverse(perm_out, a)
			: iqo_pkg::tbl_lookup(perm_left, a);
		nxt.q = (op == iqo_pkg::OP_LDIV) ? iqo_pkg::tbl_inverse(perm_out, b)
			: iqo_pkg::tbl_lookup(perm_right, b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

FILE: sv/iqo_mix.sv
module iqo_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s1,
	input  iqo_pkg::s1_t      data_s1,
	input  iqo_pkg::mode_t    group_mode,
	output logic              valid_s2,
	output iqo_pkg::s2_t      data_s2
);

	iqo_pkg::s2_t nxt;

	always_comb begin
		nxt.op = data_s1.op;
		case (data_s1.op)
			iqo_pkg::OP_LDIV: begin
				// p = left image of x, q = outer preimage of z
				case (group_mode)
					iqo_pkg::MODE_ADD: nxt.g = data_s1.q - data_s1.p;
					iqo_pkg::MODE_SUB: nxt.g = data_s1.p - data_s1.q;
					default:           nxt.g = data_s1.p ^ data_s1.q;
				endcase
			end
			iqo_pkg::OP_RDIV: begin
				// p = outer preimage of z, q = right image of y
				case (group_mode)
					iqo_pkg::MODE_ADD: nxt.g = data_s1.p - data_s1.q;
					iqo_pkg::MODE_SUB: nxt.g = data_s1.p + data_s1.q;
					default:           nxt.g = data_s1.p ^ data_s1.q;
				endcase
			end
			default: begin
				case (group_mode)
					iqo_pkg::MODE_ADD: nxt.g = data_s1.p + data_s1.q;
					iqo_pkg::MODE_SUB: nxt.g = data_s1.p - data_s1.q;
					default:           nxt.g = data_s1.p ^ data_s1.q;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

endmodule

FILE: sv/iqo_back.sv
module iqo_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s2,
	input  iqo_pkg::s2_t      data_s2,
	input  iqo_pkg::table_t   perm_out,
	input  iqo_pkg::table_t   perm_left,
	input  iqo_pkg::table_t   perm_right,
	output logic              valid_s3,
	output iqo_pkg::elem_t    answer_s3
);

	iqo_pkg::elem_t nxt;

	always_comb begin
		case (data_s2.op)
			iqo_pkg::OP_LDIV: nxt = iqo_pkg::tbl_inverse(perm_right, data_s2.g);
			iqo_pkg::OP_RDIV: nxt = iqo_pkg::tbl_inverse(perm_left, data_s2.g);
			default:          nxt = iqo_pkg::tbl_lookup(perm_out, data_s2.g);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			answer_s3 <= nxt;
		end
	end

endmodule

FILE: sv/isotope_quasigroup_op_top.sv
// Order-8 quasigroup operator, an isotope of XOR, addition or subtraction
// mod 8 under three configured tables: z = perm_out[perm_left[x] op
// perm_right[y]]. Each item on in_ch asks for a product (opcode 0), a left
// division finding y from x and z (opcode 1) or a right division finding x
// from z and y (opcode 2); opcode 3 acts as a product and group mode 3 as
// XOR. Inverse lookups take the lowest matching table index, or 0 when no
// entry matches, so tables that are not permutations still give defined
// answers. The block takes one item per cycle, while in_ch.ready is high,
// and returns its answer on out_ch through three register stages (table
// lookup or inversion, group operation, final lookup or inversion), the
// last of which is the output register. Stages hold on back-pressure and
// bubbles are squeezed out, so in_ch.ready drops only when all three
// stages are full and out_ch is stalled. Write the configuration registers
// (cfg_index 0 perm_out, 1 perm_left, 2 perm_right, 3 group_mode) only
// while no item is in flight; reset loads identity tables and XOR.
module isotope_quasigroup_op_top (
	input  logic                 clk,
	input  logic                 arst_n,
	iqo_in_if.sink               in_ch,
	iqo_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  iqo_pkg::cfg_idx_t    cfg_index,
	input  iqo_pkg::table_t      cfg_wdata
);

	iqo_pkg::table_t perm_out_q;
	iqo_pkg::table_t perm_left_q;
	iqo_pkg::table_t perm_right_q;
	iqo_pkg::mode_t  group_mode_q;

	logic           valid_s1;
	logic           valid_s2;
	logic           valid_s3;
	iqo_pkg::s1_t   data_s1;
	iqo_pkg::s2_t   data_s2;
	iqo_pkg::elem_t answer_s3;

	logic en_s1;
	logic en_s2;
	logic en_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_out_q   <= iqo_pkg::IDENTITY;
			perm_left_q  <= iqo_pkg::IDENTITY;
			perm_right_q <= iqo_pkg::IDENTITY;
			group_mode_q <= iqo_pkg::MODE_XOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iqo_pkg::REG_PERM_OUT:   perm_out_q   <= cfg_wdata;
				iqo_pkg::REG_PERM_LEFT:  perm_left_q  <= cfg_wdata;
				iqo_pkg::REG_PERM_RIGHT: perm_right_q <= cfg_wdata;
				iqo_pkg::REG_GROUP_MODE: group_mode_q <= cfg_wdata[iqo_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or the stage after it moves
	assign en_s3 = !valid_s3 || out_ch.ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign in_ch.ready = en_s1;

	iqo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_s1),
		.valid_in   (in_ch.valid),
		.op         (in_ch.opcode),
		.a          (in_ch.first_operand),
		.b          (in_ch.second_operand),
		.perm_out   (perm_out_q),
		.perm_left  (perm_left_q),
		.perm_right (perm_right_q),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	iqo_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_s2),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.group_mode (group_mode_q),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2)
	);

	iqo_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_s3),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.perm_out   (perm_out_q),
		.perm_left  (perm_left_q),
		.perm_right (perm_right_q),
		.valid_s3   (valid_s3),
		.answer_s3  (answer_s3)
	);

	assign out_ch.valid  = valid_s3;
	assign out_ch.answer = answer_s3;

	// An accepted item lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> valid_s1)
		else $error("accepted item missing from stage 1");

	// A full pipe with a stalled output refuses new items
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !out_ch.ready |-> !in_ch.ready)
		else $error("input accepted while pipeline full and stalled");

	// A stage 2 item blocked by stage 3 holds its contents
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en_s3 |=> valid_s2 && $stable(data_s2))
		else $error("stage 2 item lost or changed during stall");

	// A stage 1 item blocked by stage 2 holds its contents
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en_s2 |=> valid_s1 && $stable(data_s1))
		else $error("stage 1 item lost or changed during stall");

endmodule

FILE: verif/tb_isotope_quasigroup_op_top.sv
`timescale 1ns / 1ps

module tb_isotope_quasigroup_op_top;
	import iqo_pkg::*;

	// Codes the package leaves unnamed; the block folds them onto XOR and product
	localparam mode_t MODE_SPARE = 2'd3;
	localparam op_t OP_SPARE = 2'd3;

	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int MAX_IDLE = 12;
	localparam int CYCLE_LIMIT = 400000;

	// Predicts each answer from its own copy of the three tables and the group
	// mode, then holds the answers in order until the output side takes them.
	class answer_board;
		table_t tbl_out;
		table_t tbl_left;
		table_t tbl_right;
		mode_t  mode;
		elem_t  answer_q[$];
		int     mismatches;
		int     compared;
		int     op_seen[4];

		function new();
			tbl_out = IDENTITY;
			tbl_left = IDENTITY;
			tbl_right = IDENTITY;
			mode = MODE_XOR;
			mismatches = 0;
			compared = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, table_t data);
			case (idx)
				REG_PERM_OUT: tbl_out = data;
				REG_PERM_LEFT: tbl_left = data;
				REG_PERM_RIGHT: tbl_right = data;
				REG_GROUP_MODE: mode = mode_t'(data[MODE_W-1:0]);
				default: ;
			endcase
		endfunction

		function elem_t entry(table_t t, elem_t i);
			return elem_t'(t >> (i * ELEMENT_BITS));
		endfunction

		// Lowest index holding v, zero if none does
		function elem_t preimage(table_t t, elem_t v);
			elem_t idx;
			bit    found;
			idx = '0;
			found = 1'b0;
			for (int i = 0; i < ORDER; i++) begin
				if (!found && entry(t, elem_t'(i)) == v) begin
					idx = elem_t'(i);
					found = 1'b1;
				end
			end
			return idx;
		endfunction

		function elem_t quasi_answer(op_t op, elem_t a, elem_t b);
			elem_t l;
			elem_t r;
			elem_t w;
			elem_t g;
			elem_t res;
			case (op)
				OP_LDIV: begin
					l = entry(tbl_left, a);
					w = preimage(tbl_out, b);
					case (mode)
						MODE_ADD: g = w - l;
						MODE_SUB: g = l - w;
						default: g = l ^ w;
					endcase
					res = preimage(tbl_right, g);
				end
				OP_RDIV: begin
					r = entry(tbl_right, b);
					w = preimage(tbl_out, a);
					case (mode)
						MODE_ADD: g = w - r;
						MODE_SUB: g = w + r;
						default: g = w ^ r;
					endcase
					res = preimage(tbl_left, g);
				end
				default: begin
					l = entry(tbl_left, a);
					r = entry(tbl_right, b);
					case (mode)
						MODE_ADD: g = l + r;
						MODE_SUB: g = l - r;
						default: g = l ^ r;
					endcase
					res = entry(tbl_out, g);
				end
			endcase
			return res;
		endfunction

		function void note_item(op_t op, elem_t a, elem_t b);
			answer_q.push_back(quasi_answer(op, a, b));
			op_seen[op]++;
		endfunction

		function void check_answer(elem_t got);
			elem_t want;
			if (answer_q.size() == 0) begin
				mismatches++;
				$display("%0t: answer %0d arrived with nothing expected", $time, got);
			end else begin
				want = answer_q.pop_front();
				compared++;
				if (got !== want) begin
					mismatches++;
					$display("%0t: answer mismatch, expected %0d, actual %0d",
						$time, want, got);
				end
			end
		endfunction

		function int pending();
			return answer_q.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	table_t   cfg_wdata;

	iqo_in_if  in_ch();
	iqo_out_if out_ch();

	answer_board board = new();

	// Per-phase switches: when clear, that side runs flat out
	bit src_idle;
	bit snk_idle;
	int settings_used;
	int unsigned cycles = 0;

	isotope_quasigroup_op_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Drive every input known from time zero
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PERM_OUT;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.opcode <= OP_PRODUCT;
		in_ch.first_operand <= '0;
		in_ch.second_operand <= '0;
		out_ch.ready <= 1'b0;
	end

	// Output side: stall a random number of cycles, then hold ready until an
	// answer is taken; check each answer at the edge it is accepted.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = snk_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			board.check_answer(out_ch.answer);
		end
	end

	// Present one item after an optional gap and hold it until accepted.
	// Valid stays high on return so back-to-back items need no extra edge.
	task automatic send_item(op_t op, elem_t a, elem_t b);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.first_operand <= a;
		in_ch.second_operand <= b;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		board.note_item(op, a, b);
	endtask

	// Drop valid and wait for every outstanding answer
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, table_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		board.set_reg(idx, data);
		@(posedge clk);
	endtask

	// Mode write carries random upper bits; the block keeps only the low two
	task automatic write_config(table_t t_out, table_t t_left, table_t t_right, mode_t m);
		table_t mode_word;
		mode_word = table_t'($urandom);
		mode_word[MODE_W-1:0] = m;
		put_reg(REG_PERM_OUT, t_out);
		put_reg(REG_PERM_LEFT, t_left);
		put_reg(REG_PERM_RIGHT, t_right);
		put_reg(REG_GROUP_MODE, mode_word);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mostly true permutations; one in four is an arbitrary, likely
	// non-bijective table to exercise the lowest-match inverse rule
	function automatic table_t random_table();
		elem_t  vals[ORDER];
		elem_t  tmp;
		table_t t;
		int     j;
		if ($urandom_range(0, 3) == 0)
			return table_t'($urandom);
		foreach (vals[i]) vals[i] = elem_t'(i);
		for (int i = ORDER - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = vals[i];
			vals[i] = vals[j];
			vals[j] = tmp;
		end
		t = '0;
		foreach (vals[i]) t[i*ELEMENT_BITS +: ELEMENT_BITS] = vals[i];
		return t;
	endfunction

	initial begin
		int    n_rand;
		op_t   ops[4];
		elem_t ext[2];
		ops = '{OP_PRODUCT, OP_LDIV, OP_RDIV, OP_SPARE};
		ext = '{elem_t'(0), elem_t'(ORDER - 1)};
		settings_used = 1;
		src_idle = 1'b0;
		snk_idle = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			// Vary which side idles so some phases run at full rate
			src_idle = (p % 4) != 2;
			snk_idle = (p % 4) != 3;
			n_rand = ITEMS_PER_PHASE;

			if (p > 0) begin
				drain();
				case (p)
					// Constant tables: every inverse of a constant table falls back on index zero
					1: write_config('0, '1, random_table(), MODE_ADD);
					2: write_config('1, '0, '0, MODE_SUB);
					// Group mode three must behave as XOR
					3: write_config(random_table(), random_table(), random_table(),
						MODE_SPARE);
					4: write_config(random_table(), random_table(), random_table(),
						MODE_SUB);
					default: write_config(random_table(), random_table(), random_table(),
						mode_t'($urandom_range(0, 3)));
				endcase
			end else begin
				// Reset state: identity tables, XOR. Hit every opcode, including
				// the spare one, with every corner of the operand range.
				foreach (ops[o])
					foreach (ext[i])
						foreach (ext[k])
							send_item(ops[o], ext[i], ext[k]);
				n_rand = ITEMS_PER_PHASE - 16;
			end

			for (int n = 0; n < n_rand; n++) begin
				// In odd phases hold off halfway until the pipeline is empty
				if (p % 2 == 1 && n == n_rand / 2)
					drain();
				send_item(op_t'($urandom_range(0, 3)),
					elem_t'($urandom_range(0, ORDER - 1)),
					elem_t'($urandom_range(0, ORDER - 1)));
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Ran %0d table settings; items by opcode: product %0d, left div %0d, "
			, settings_used, board.op_seen[OP_PRODUCT], board.op_seen[OP_LDIV]);
		$display("right div %0d, spare opcode %0d; %0d answers compared, %0d mismatches",
			board.op_seen[OP_RDIV], board.op_seen[OP_SPARE], board.compared,
			board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
